/* rtl/core/clmt_pkg.sv */
// ----------------------------------------------------------------------------
// clmt_pkg
// Shared types and codes for the connection log merge table.
// ----------------------------------------------------------------------------
package clmt_pkg;

    typedef enum logic [1:0] {
        CMD_LOG    = 2'd0,
        CMD_REWIND = 2'd1,
        CMD_READ   = 2'd2,
        CMD_CLEAR  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_MERGED   = 3'd0,
        ST_APPENDED = 3'd1,
        ST_FULL     = 3'd2,
        ST_ENTRY    = 3'd3,
        ST_END      = 3'd4,
        ST_DONE     = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_WRITE,
        S_RDWAIT,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic [7:0]  protocol;
        logic [7:0]  action;
        logic [2:0]  hook;
        logic [31:0] source_address;
        logic [31:0] destination_address;
        logic [15:0] source_port;
        logic [15:0] destination_port;
        logic [7:0]  reason;
    } t_key;

    typedef struct packed {
        t_key        key;
        logic [31:0] time_stamp;
        logic [31:0] hits;
    } t_entry;

    typedef struct packed {
        t_cmd        command;
        t_key        key;
        logic [31:0] time_stamp;
    } t_req;

    typedef struct packed {
        t_status status;
        t_entry  entry;
    } t_rsp;

    localparam int ENTRY_W = $bits(t_entry);
    localparam logic [31:0] HITS_MAX = 32'hFFFF_FFFF;

endpackage

/* rtl/core/clmt_ram.sv */
// ----------------------------------------------------------------------------
// clmt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module clmt_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/core/clmt_engine.sv */
// ----------------------------------------------------------------------------
// clmt_engine
// Sequencer that scans the log memory through one key comparator, merges
// or appends events, and serves cursor rewinds, reads and clears.
// ----------------------------------------------------------------------------
module clmt_engine import clmt_pkg::*; #(
    parameter int LOG_DEPTH = 64,
    parameter int CNT_W     = 7,
    parameter int IDX_W     = 6
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  t_req             i_req,
    output logic             o_rsp_valid,
    input  logic             i_rsp_ready,
    output t_rsp             o_rsp,
    output logic [CNT_W-1:0] o_rows_used
);

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_count, n_count;
    logic [CNT_W-1:0]   r_cursor, n_cursor;
    logic [CNT_W-1:0]   r_scan, n_scan;
    logic               r_pend, n_pend;
    logic [IDX_W-1:0]   r_pidx, n_pidx;
    logic [IDX_W-1:0]   r_widx, n_widx;
    t_req               r_req, n_req;
    t_status            r_status, n_status;
    t_entry             r_row, n_row;

    logic               ram_we;
    logic [IDX_W-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry             rd_entry;
    logic               key_hit;
    logic               has_room;

    clmt_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (LOG_DEPTH),
        .ADDR_W (IDX_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_widx),
        .i_wdata (r_row),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_entry = t_entry'(ram_rdata);
    assign key_hit  = r_pend && (rd_entry.key == r_req.key);
    assign has_room = r_count < CNT_W'(LOG_DEPTH);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    case (i_req.command)
                        CMD_LOG:  n_state = S_SCAN;
                        CMD_READ: n_state = (r_cursor < r_count) ? S_RDWAIT : S_EMIT;
                        default:  n_state = S_EMIT;
                    endcase
                end
            end
            S_SCAN: begin
                if (key_hit) begin
                    n_state = S_WRITE;
                end else if (r_scan < r_count) begin
                    n_state = S_SCAN;
                end else if (has_room) begin
                    n_state = S_WRITE;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_WRITE:  n_state = S_EMIT;
            S_RDWAIT: n_state = S_EMIT;
            S_EMIT: begin
                if (i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_cursor  = r_cursor;
        n_scan    = r_scan;
        n_pend    = 1'b0;
        n_pidx    = r_pidx;
        n_widx    = r_widx;
        n_req     = r_req;
        n_status  = r_status;
        n_row     = r_row;
        ram_we    = 1'b0;
        ram_raddr = r_cursor[IDX_W-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_row = '0;
                    case (i_req.command)
                        CMD_LOG: begin
                            n_req  = i_req;
                            n_scan = '0;
                        end
                        CMD_REWIND: begin
                            n_cursor = '0;
                            n_status = ST_DONE;
                        end
                        CMD_READ: begin
                            n_status = ST_END;
                        end
                        default: begin
                            n_count  = '0;
                            n_cursor = '0;
                            n_status = ST_DONE;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                ram_raddr = r_scan[IDX_W-1:0];
                if (key_hit) begin
                    n_row.key        = rd_entry.key;
                    n_row.time_stamp = r_req.time_stamp;
                    n_row.hits       = (rd_entry.hits == HITS_MAX) ? HITS_MAX
                                                                   : rd_entry.hits + 32'd1;
                    n_widx           = r_pidx;
                    n_status         = ST_MERGED;
                end else if (r_scan < r_count) begin
                    n_pend = 1'b1;
                    n_pidx = r_scan[IDX_W-1:0];
                    n_scan = r_scan + CNT_W'(1);
                end else if (has_room) begin
                    n_row.key        = r_req.key;
                    n_row.time_stamp = r_req.time_stamp;
                    n_row.hits       = 32'd1;
                    n_widx           = r_count[IDX_W-1:0];
                    n_count          = r_count + CNT_W'(1);
                    n_status         = ST_APPENDED;
                end else begin
                    n_row    = '0;
                    n_status = ST_FULL;
                end
            end
            S_WRITE: begin
                ram_we = 1'b1;
            end
            S_RDWAIT: begin
                n_row    = rd_entry;
                n_status = ST_ENTRY;
                n_cursor = r_cursor + CNT_W'(1);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_cursor <= '0;
            r_pend   <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_cursor <= n_cursor;
            r_pend   <= n_pend;
        end
        r_scan   <= n_scan;
        r_pidx   <= n_pidx;
        r_widx   <= n_widx;
        r_req    <= n_req;
        r_status <= n_status;
        r_row    <= n_row;
    end

    assign o_req_ready  = (r_state == S_IDLE);
    assign o_rsp_valid  = (r_state == S_EMIT);
    assign o_rsp.status = r_status;
    assign o_rsp.entry  = r_row;
    assign o_rows_used  = r_count;

endmodule

/* rtl/core/connection_log_merge_table.sv */
// ----------------------------------------------------------------------------
// connection_log_merge_table
// Packet-decision log table that merges repeated events by key.
// Sequence: rewind, clear and a read past the end go straight to the response;
//   a read of a stored entry first waits on the registered RAM read; a log event
//   scans up to N stored entries (at most LOG_DEPTH), then writes or reports full.
// Throughput: one transaction at a time, set by the one-entry-per-cycle scan of
//   the log memory through one key comparator. Every response passes the output register.
// Reset: synchronous, active low; empties the table and rewinds the cursor.
// ----------------------------------------------------------------------------
module connection_log_merge_table import clmt_pkg::*; #(
    parameter int  LOG_DEPTH = 64,
    localparam int CNT_W     = $clog2(LOG_DEPTH + 1),
    localparam int IDX_W     = (LOG_DEPTH > 1) ? $clog2(LOG_DEPTH) : 1,
    localparam int M_BITS    = ENTRY_W + CNT_W,
    localparam int M_DATA_W  = ((M_BITS + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // protocol, action, hook, source_address, destination_address,
    // source_port, destination_port, reason, timestamp, zero pad
    input  logic [159:0]           s_axis_tdata,
    // command
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // row_protocol, row_action, row_hook, row_source_address,
    // row_destination_address, row_source_port, row_destination_port,
    // row_reason, row_time, row_hits, rows_used, zero pad
    output logic [M_DATA_W-1:0]    m_axis_tdata,
    // status
    output logic [2:0]             m_axis_tuser
);

    t_req             req;
    t_rsp             rsp;
    logic             rsp_valid;
    logic             rsp_ready;
    logic [CNT_W-1:0] rows_used;

    logic             r_valid;
    t_rsp             r_rsp;
    logic [CNT_W-1:0] r_rows_used;

    assign req.command                 = t_cmd'(s_axis_tuser);
    assign req.key.protocol            = s_axis_tdata[7:0];
    assign req.key.action              = s_axis_tdata[15:8];
    assign req.key.hook                = s_axis_tdata[18:16];
    assign req.key.source_address      = s_axis_tdata[50:19];
    assign req.key.destination_address = s_axis_tdata[82:51];
    assign req.key.source_port         = s_axis_tdata[98:83];
    assign req.key.destination_port    = s_axis_tdata[114:99];
    assign req.key.reason              = s_axis_tdata[122:115];
    assign req.time_stamp              = s_axis_tdata[154:123];

    clmt_engine #(
        .LOG_DEPTH (LOG_DEPTH),
        .CNT_W     (CNT_W),
        .IDX_W     (IDX_W)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (req),
        .o_rsp_valid (rsp_valid),
        .i_rsp_ready (rsp_ready),
        .o_rsp       (rsp),
        .o_rows_used (rows_used)
    );

    assign rsp_ready = !r_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (rsp_ready) begin
            r_valid <= rsp_valid;
        end
        if (rsp_ready && rsp_valid) begin
            r_rsp       <= rsp;
            r_rows_used <= rows_used;
        end
    end

    assign m_axis_tvalid = r_valid;
    assign m_axis_tuser  = r_rsp.status;

    always_comb begin
        m_axis_tdata                              = '0;
        m_axis_tdata[7:0]                         = r_rsp.entry.key.protocol;
        m_axis_tdata[15:8]                        = r_rsp.entry.key.action;
        m_axis_tdata[18:16]                       = r_rsp.entry.key.hook;
        m_axis_tdata[50:19]                       = r_rsp.entry.key.source_address;
        m_axis_tdata[82:51]                       = r_rsp.entry.key.destination_address;
        m_axis_tdata[98:83]                       = r_rsp.entry.key.source_port;
        m_axis_tdata[114:99]                      = r_rsp.entry.key.destination_port;
        m_axis_tdata[122:115]                     = r_rsp.entry.key.reason;
        m_axis_tdata[154:123]                     = r_rsp.entry.time_stamp;
        m_axis_tdata[186:155]                     = r_rsp.entry.hits;
        m_axis_tdata[ENTRY_W +: CNT_W]            = r_rows_used;
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the connection log merge table against a behavioral copy of the
// table kept here. Directed tasks walk through the empty table, merge and
// append, readback past the end, clear, a full table and a long output
// stall. Random traffic follows. Both stream sides idle at random, and every
// result is compared field by field in order.
// ----------------------------------------------------------------------------
module testbench import clmt_pkg::*;;

    localparam int DEPTH        = 64;
    localparam int IDLE_MAX     = 12;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 670;
    localparam int POOL_SIZE    = 48;

    typedef struct packed {
        t_status     status;
        t_entry      entry;
        logic [6:0]  used;
    } t_row_result;

    typedef struct packed {
        logic [4:0]  pad;
        logic [31:0] stamp;
        logic [7:0]  reason;
        logic [15:0] dport;
        logic [15:0] sport;
        logic [31:0] daddr;
        logic [31:0] saddr;
        logic [2:0]  hook;
        logic [7:0]  action;
        logic [7:0]  protocol;
    } t_event_word;

    typedef struct packed {
        logic [5:0]  pad;
        logic [6:0]  used;
        logic [31:0] hits;
        logic [31:0] stamp;
        logic [7:0]  reason;
        logic [15:0] dport;
        logic [15:0] sport;
        logic [31:0] daddr;
        logic [31:0] saddr;
        logic [2:0]  hook;
        logic [7:0]  action;
        logic [7:0]  protocol;
    } t_row_word;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [159:0] s_axis_tdata;  // protocol, action, hook, saddr, daddr, sport, dport,
                                 // reason, timestamp, zero pad
    logic [1:0]   s_axis_tuser;  // command
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [199:0] m_axis_tdata;  // protocol, action, hook, saddr, daddr, sport, dport,
                                 // reason, time, hits, rows_used, zero pad
    logic [2:0]   m_axis_tuser;  // status

    t_key         tab_key [DEPTH];
    logic [31:0]  tab_stamp [DEPTH];
    logic [31:0]  tab_hits [DEPTH];
    int           tab_count;
    int           tab_cursor;
    t_row_result  expected_rows[$];
    int           mismatch_count;
    bit           tx_idle_on;
    bit           rx_idle_on;
    int           hold_request;
    t_key         key_pool [POOL_SIZE];

    connection_log_merge_table #(
        .LOG_DEPTH(DEPTH)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        i_clk = 1'b1;
        #6;
        i_clk = 1'b0;
        #6;
    end

    function automatic t_row_result table_apply(t_cmd cmd, t_key key, logic [31:0] stamp);
        t_row_result res;
        int          hit;
        res = '0;
        hit = -1;
        case (cmd)
            CMD_LOG: begin
                for (int i = 0; i < tab_count; i++) begin
                    if (hit < 0 && tab_key[i] == key) hit = i;
                end
                if (hit >= 0) begin
                    tab_stamp[hit] = stamp;
                    if (tab_hits[hit] != HITS_MAX) tab_hits[hit] = tab_hits[hit] + 1;
                    res.status = ST_MERGED;
                end else if (tab_count < DEPTH) begin
                    hit = tab_count;
                    tab_key[hit]   = key;
                    tab_stamp[hit] = stamp;
                    tab_hits[hit]  = 32'd1;
                    tab_count++;
                    res.status = ST_APPENDED;
                end else begin
                    res.status = ST_FULL;
                end
            end
            CMD_REWIND: begin
                tab_cursor = 0;
                res.status = ST_DONE;
            end
            CMD_READ: begin
                if (tab_cursor < tab_count) begin
                    hit = tab_cursor;
                    tab_cursor++;
                    res.status = ST_ENTRY;
                end else begin
                    res.status = ST_END;
                end
            end
            default: begin
                tab_count  = 0;
                tab_cursor = 0;
                res.status = ST_DONE;
            end
        endcase
        if (hit >= 0) begin
            res.entry.key        = tab_key[hit];
            res.entry.time_stamp = tab_stamp[hit];
            res.entry.hits       = tab_hits[hit];
        end
        res.used = tab_count[6:0];
        return res;
    endfunction

    function automatic t_key random_key();
        t_key k;
        k.protocol            = 8'($urandom);
        k.action              = 8'($urandom);
        k.hook                = 3'($urandom);
        k.source_address      = $urandom;
        k.destination_address = $urandom;
        k.source_port         = 16'($urandom);
        k.destination_port    = 16'($urandom);
        k.reason              = 8'($urandom);
        return k;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("%0t mismatch on %s: got %h, expected %h", $realtime, what, got, want);
        mismatch_count++;
    endtask

    task automatic send_item(t_cmd cmd, t_key key, logic [31:0] stamp);
        t_event_word w;
        int          gap;
        gap = tx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
        w.pad      = '0;
        w.stamp    = stamp;
        w.reason   = key.reason;
        w.dport    = key.destination_port;
        w.sport    = key.source_port;
        w.daddr    = key.destination_address;
        w.saddr    = key.source_address;
        w.hook     = key.hook;
        w.action   = key.action;
        w.protocol = key.protocol;
        @(negedge i_clk);
        if (gap != 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= w;
        s_axis_tuser  <= cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        expected_rows.push_back(table_apply(cmd, key, stamp));
    endtask

    task automatic send_other(t_cmd cmd);
        send_item(cmd, random_key(), $urandom);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (expected_rows.size() != 0) @(posedge i_clk);
    endtask

    // receive side: check each transaction, then draw the next stall
    initial begin
        t_row_word   got;
        t_row_result want;
        int          rx_wait;
        int          hold_left;
        rx_wait       = 0;
        hold_left     = 0;
        m_axis_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                got = m_axis_tdata;
                if (expected_rows.size() == 0) begin
                    report_mismatch("result with nothing expected", 32'(m_axis_tuser), '0);
                end else begin
                    want = expected_rows.pop_front();
                    if (m_axis_tuser != want.status)
                        report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
                    if (got.protocol != want.entry.key.protocol)
                        report_mismatch("row_protocol", 32'(got.protocol),
                                        32'(want.entry.key.protocol));
                    if (got.action != want.entry.key.action)
                        report_mismatch("row_action", 32'(got.action),
                                        32'(want.entry.key.action));
                    if (got.hook != want.entry.key.hook)
                        report_mismatch("row_hook", 32'(got.hook),
                                        32'(want.entry.key.hook));
                    if (got.saddr != want.entry.key.source_address)
                        report_mismatch("row_source_address", got.saddr,
                                        want.entry.key.source_address);
                    if (got.daddr != want.entry.key.destination_address)
                        report_mismatch("row_destination_address", got.daddr,
                                        want.entry.key.destination_address);
                    if (got.sport != want.entry.key.source_port)
                        report_mismatch("row_source_port", 32'(got.sport),
                                        32'(want.entry.key.source_port));
                    if (got.dport != want.entry.key.destination_port)
                        report_mismatch("row_destination_port", 32'(got.dport),
                                        32'(want.entry.key.destination_port));
                    if (got.reason != want.entry.key.reason)
                        report_mismatch("row_reason", 32'(got.reason),
                                        32'(want.entry.key.reason));
                    if (got.stamp != want.entry.time_stamp)
                        report_mismatch("row_time", got.stamp, want.entry.time_stamp);
                    if (got.hits != want.entry.hits)
                        report_mismatch("row_hits", got.hits, want.entry.hits);
                    if (got.used != want.used)
                        report_mismatch("rows_used", 32'(got.used), 32'(want.used));
                    if (got.pad != '0)
                        report_mismatch("tdata pad", 32'(got.pad), '0);
                end
                rx_wait = rx_idle_on ? $urandom_range(0, IDLE_MAX) : 0;
            end
            @(negedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (rx_wait > 0) begin
                rx_wait--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // end the run when no transaction moves for too long
    initial begin
        int quiet;
        quiet = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet = 0;
            else
                quiet++;
            if (quiet >= STALL_LIMIT) begin
                $display("%0t timeout: no transaction for %0d cycles", $realtime, quiet);
                $display("testbench: FAIL");
                $finish;
            end
        end
    end

    task automatic test_empty_table();
        send_other(CMD_CLEAR);
        send_other(CMD_READ);
        send_other(CMD_REWIND);
        send_other(CMD_READ);
        wait_idle();
    endtask

    task automatic test_append_merge();
        t_key base;
        t_key k;
        base = '0;
        send_item(CMD_LOG, base, 32'h0000_0000);
        send_item(CMD_LOG, base, 32'hFFFF_FFFF);
        send_item(CMD_LOG, '1, 32'h8000_0000);
        send_item(CMD_LOG, '1, 32'h0000_0001);
        // flip one key field at a time: each first flip must miss; the repeated reason flip merges
        k = base; k.protocol            = 8'hFF;        send_item(CMD_LOG, k, 32'd10);
        k = base; k.action              = 8'hFF;        send_item(CMD_LOG, k, 32'd11);
        k = base; k.hook                = 3'h7;         send_item(CMD_LOG, k, 32'd12);
        k = base; k.source_address      = 32'hFFFF_FFFF; send_item(CMD_LOG, k, 32'd13);
        k = base; k.destination_address = 32'hFFFF_FFFF; send_item(CMD_LOG, k, 32'd14);
        k = base; k.source_port         = 16'hFFFF;     send_item(CMD_LOG, k, 32'd15);
        k = base; k.destination_port    = 16'hFFFF;     send_item(CMD_LOG, k, 32'd16);
        k = base; k.reason              = 8'h80;        send_item(CMD_LOG, k, 32'd17);
        k = base; k.reason              = 8'h7F;        send_item(CMD_LOG, k, 32'd18);
        k = base; k.reason              = 8'h80;        send_item(CMD_LOG, k, 32'd19);
        wait_idle();
    endtask

    task automatic test_readback();
        int n;
        n = tab_count;
        send_other(CMD_REWIND);
        repeat (n + 2) send_other(CMD_READ);
        send_item(CMD_LOG, random_key(), $urandom);
        send_other(CMD_READ);
        send_other(CMD_READ);
        wait_idle();
    endtask

    task automatic test_clear();
        t_key k;
        k = random_key();
        send_other(CMD_CLEAR);
        send_other(CMD_READ);
        send_item(CMD_LOG, k, 32'd1);
        send_item(CMD_LOG, k, 32'd2);
        send_other(CMD_REWIND);
        send_other(CMD_READ);
        send_other(CMD_READ);
        wait_idle();
    endtask

    task automatic test_full_table();
        t_key first;
        send_other(CMD_CLEAR);
        first = random_key();
        send_item(CMD_LOG, first, $urandom);
        while (tab_count < DEPTH) send_item(CMD_LOG, random_key(), $urandom);
        send_item(CMD_LOG, random_key(), $urandom);
        send_item(CMD_LOG, first, 32'hFFFF_FFFF);
        send_item(CMD_LOG, tab_key[DEPTH-1], 32'h1234_5678);
        send_other(CMD_REWIND);
        repeat (3) send_other(CMD_READ);
        wait_idle();
    endtask

    task automatic test_backpressure();
        hold_request = 400;
        repeat (20) begin
            if ($urandom_range(0, 3) == 0) send_other(CMD_READ);
            else send_item(CMD_LOG, key_pool[$urandom_range(0, 7)], $urandom);
        end
        wait_idle();
    endtask

    task automatic test_random_traffic();
        t_key                    k;
        logic [$bits(t_key)-1:0] flip;
        int                      pick;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n % 100 == 0) begin
                tx_idle_on = ($urandom_range(0, 3) != 0);
                rx_idle_on = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 999);
            if (pick < 700) begin
                if ($urandom_range(0, 9) < 7) k = key_pool[$urandom_range(0, POOL_SIZE-1)];
                else k = random_key();
                if ($urandom_range(0, 9) == 0) begin
                    flip = '0;
                    flip[$urandom_range(0, $bits(t_key)-1)] = 1'b1;
                    k = t_key'(k ^ flip);
                end
                send_item(CMD_LOG, k, $urandom);
            end else if (pick < 930) begin
                send_other(CMD_READ);
            end else if (pick < 985) begin
                send_other(CMD_REWIND);
            end else begin
                send_other(CMD_CLEAR);
            end
        end
        wait_idle();
    endtask

    initial begin
        mismatch_count = 0;
        tab_count      = 0;
        tab_cursor     = 0;
        hold_request   = 0;
        tx_idle_on     = 1'b1;
        rx_idle_on     = 1'b1;
        i_rst_n        = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        s_axis_tuser   = CMD_LOG;
        for (int i = 0; i < POOL_SIZE; i++) key_pool[i] = random_key();
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_table();
        test_append_merge();
        test_readback();
        test_clear();
        test_full_table();
        test_backpressure();
        test_random_traffic();

        repeat (80) @(posedge i_clk);
        if (expected_rows.size() != 0)
            report_mismatch("results never delivered", expected_rows.size(), '0);
        if (mismatch_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

/* sim.f */
rtl/core/clmt_pkg.sv
rtl/core/clmt_ram.sv
rtl/core/clmt_engine.sv
rtl/core/connection_log_merge_table.sv
tb/testbench.sv
